### rtl/page_residency_budget_admission_assert.svh
// Assertion macros used by the page admission checker
`ifndef PAGE_RESIDENCY_BUDGET_ADMISSION_ASSERT_SVH
`define PAGE_RESIDENCY_BUDGET_ADMISSION_ASSERT_SVH

// consequent checked in the cycle after the antecedent, off during reset
`define PRBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page admission: next-cycle check failed");

// consequent checked in the same cycle, off during reset
`define PRBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page admission: same-cycle check failed");

// active during reset as well
`define PRBA_ASSERT_RESET(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("page admission: reset check failed");

`endif

### rtl/prba_pkg.sv
// Package: widths, command kinds, register indexes and word types for page admission
`timescale 1ns / 1ps

package prba_pkg;

    localparam int TAG_W      = 32;
    localparam int LVL_W      = 4;
    localparam int PTS_W      = 32;
    localparam int BYTES_W    = 40;
    localparam int ATTR_W     = 16;
    localparam int TOKEN_W    = 64;
    localparam int ACC_B_W    = 48;
    localparam int ACC_P_W    = 40;
    localparam int SLOT_W     = 16;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int SUM_B_W    = ACC_B_W + 1;
    localparam int SUM_P_W    = ACC_P_W + 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_REQUEST     = 3'd0,
        KIND_READ        = 3'd1,
        KIND_UPLOAD      = 3'd2,
        KIND_BIND        = 3'd3,
        KIND_DRAW        = 3'd4,
        KIND_SKIP_BYTES  = 3'd5,
        KIND_SKIP_POINTS = 3'd6
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_BUDGET   = 3'd0,
        CFG_RESIDENT_LIMIT = 3'd1,
        CFG_UPLOAD_BUDGET  = 3'd2,
        CFG_POINT_LIMIT    = 3'd3,
        CFG_PAGE_LIMIT     = 3'd4,
        CFG_PREFETCH_SLOTS = 3'd5,
        CFG_KEEP_COARSE    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic               frame_start;
        logic [TAG_W-1:0]   page_tag;
        logic [LVL_W-1:0]   level;
        logic [PTS_W-1:0]   point_count;
        logic [BYTES_W-1:0] page_bytes;
        logic               is_prefetch;
        logic [ATTR_W-1:0]  attr_mask;
        logic [TOKEN_W-1:0] gpu_token;
    } t_page;

    // command plan for one page: the sequence runs from the first kind up to last_kind
    typedef struct packed {
        t_page page;
        logic  pf;
        t_kind last_kind;
    } t_plan;

endpackage

### rtl/prba_if.sv
// Channel interfaces: page words in, command words out, register writes
`timescale 1ns / 1ps

interface prba_page_if;
    logic                          valid;
    logic                          ready;
    logic                          frame_start;
    logic [prba_pkg::TAG_W-1:0]    page_tag;
    logic [prba_pkg::LVL_W-1:0]    level;
    logic [prba_pkg::PTS_W-1:0]    point_count;
    logic [prba_pkg::BYTES_W-1:0]  page_bytes;
    logic                          is_prefetch;
    logic [prba_pkg::ATTR_W-1:0]   attr_mask;
    logic [prba_pkg::TOKEN_W-1:0]  gpu_token;

    modport source (output valid, frame_start, page_tag, level, point_count, page_bytes,
                    is_prefetch, attr_mask, gpu_token, input ready);
    modport sink   (input valid, frame_start, page_tag, level, point_count, page_bytes,
                    is_prefetch, attr_mask, gpu_token, output ready);
endinterface

interface prba_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [prba_pkg::KIND_W-1:0]   kind;
    logic [prba_pkg::TAG_W-1:0]    out_tag;
    logic [prba_pkg::LVL_W-1:0]    out_level;
    logic [prba_pkg::BYTES_W-1:0]  out_bytes;
    logic [prba_pkg::ATTR_W-1:0]   out_attr;
    logic [prba_pkg::TOKEN_W-1:0]  out_token;
    logic                          as_prefetch;
    logic                          last;

    modport source (output valid, kind, out_tag, out_level, out_bytes, out_attr, out_token,
                    as_prefetch, last, input ready);
    modport sink   (input valid, kind, out_tag, out_level, out_bytes, out_attr, out_token,
                    as_prefetch, last, output ready);
endinterface

interface prba_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [prba_pkg::CFG_IDX_W-1:0]  index;
    logic [prba_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/page_residency_budget_admission.sv
// Page admission against byte, upload and point budgets; emits per-page command words
// A page word waits in the input register until the plan register is free, then its
// decided plan loads there. Throughput: one command word per cycle while the sink is ready;
// a drawn page runs request, read, upload, bind and draw; an uploaded prefetch ends at bind;
// without upload a page ends at read; a skip is a single word; a new page enters meanwhile.
// Reset: synchronous, active low; clears configuration, accumulators and valids, not payload.
`timescale 1ns / 1ps

module page_residency_budget_admission (
    input  logic          i_clk,
    input  logic          i_rst_n,
    prba_cfg_if.sink      i_cfg,
    prba_page_if.sink     i_page,
    prba_cmd_if.source    o_cmd
);

    // configuration
    logic [prba_pkg::ACC_B_W-1:0] r_frame_budget;
    logic [prba_pkg::ACC_B_W-1:0] r_resident_limit;
    logic [prba_pkg::ACC_B_W-1:0] r_stream_budget;
    logic [prba_pkg::ACC_B_W-1:0] r_upload_budget;
    logic [prba_pkg::ACC_P_W-1:0] r_point_limit;
    logic [prba_pkg::SLOT_W-1:0]  r_prefetch_slots;
    logic                         r_keep_coarse;

    // frame accumulators
    logic [prba_pkg::ACC_B_W-1:0] r_bytes_taken,    n_bytes_taken;
    logic [prba_pkg::ACC_B_W-1:0] r_bytes_uploaded, n_bytes_uploaded;
    logic [prba_pkg::ACC_P_W-1:0] r_points_taken,   n_points_taken;
    logic [prba_pkg::SLOT_W-1:0]  r_prefetch_taken, n_prefetch_taken;

    logic            r_in_vld;
    prba_pkg::t_page r_in;
    logic            r_plan_vld;
    prba_pkg::t_plan r_plan,  n_plan;
    prba_pkg::t_kind r_kind,  n_first_kind;

    logic cmd_fire, cmd_last, plan_free, plan_load, in_fire;

    logic [prba_pkg::ACC_B_W-1:0] eff_bt, eff_bu;
    logic [prba_pkg::ACC_P_W-1:0] eff_pt;
    logic [prba_pkg::SLOT_W-1:0]  eff_pf;
    logic [prba_pkg::SUM_B_W-1:0] byte_sum, upload_sum;
    logic [prba_pkg::SUM_P_W-1:0] point_sum;
    logic over_bytes, force_ok, d_pf, skip_bytes, skip_points, admit, upload_ok;

    //--------------------------------------------------------------------------------------
    // register writes; the page limit has no effect on admission and is not stored
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_budget   <= '0;
            r_resident_limit <= '0;
            r_stream_budget  <= '0;
            r_upload_budget  <= '0;
            r_point_limit    <= '0;
            r_prefetch_slots <= '0;
            r_keep_coarse    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (prba_pkg::t_cfg_idx'(i_cfg.index))
                prba_pkg::CFG_FRAME_BUDGET: begin
                    r_frame_budget  <= i_cfg.data;
                    r_stream_budget <= (i_cfg.data < r_resident_limit) ? i_cfg.data
                                                                      : r_resident_limit;
                end
                prba_pkg::CFG_RESIDENT_LIMIT: begin
                    r_resident_limit <= i_cfg.data;
                    r_stream_budget  <= (r_frame_budget < i_cfg.data) ? r_frame_budget
                                                                      : i_cfg.data;
                end
                prba_pkg::CFG_UPLOAD_BUDGET:  r_upload_budget  <= i_cfg.data;
                prba_pkg::CFG_POINT_LIMIT:    r_point_limit    <= i_cfg.data[prba_pkg::ACC_P_W-1:0];
                prba_pkg::CFG_PAGE_LIMIT:     ;
                prba_pkg::CFG_PREFETCH_SLOTS: r_prefetch_slots <= i_cfg.data[prba_pkg::SLOT_W-1:0];
                prba_pkg::CFG_KEEP_COARSE:    r_keep_coarse    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    //--------------------------------------------------------------------------------------
    // handshakes
    assign cmd_fire  = r_plan_vld & o_cmd.ready;
    assign cmd_last  = (r_kind == r_plan.last_kind);
    assign plan_free = !r_plan_vld | (cmd_fire & cmd_last);
    assign plan_load = r_in_vld & plan_free;
    assign i_page.ready = !r_in_vld | plan_load;
    assign in_fire   = i_page.valid & i_page.ready;

    //--------------------------------------------------------------------------------------
    // admission decision on the held page word
    always_comb begin
        eff_bt = r_in.frame_start ? '0 : r_bytes_taken;
        eff_bu = r_in.frame_start ? '0 : r_bytes_uploaded;
        eff_pt = r_in.frame_start ? '0 : r_points_taken;
        eff_pf = r_in.frame_start ? '0 : r_prefetch_taken;

        byte_sum   = prba_pkg::SUM_B_W'(eff_bt) + prba_pkg::SUM_B_W'(r_in.page_bytes);
        upload_sum = prba_pkg::SUM_B_W'(eff_bu) + prba_pkg::SUM_B_W'(r_in.page_bytes);
        point_sum  = prba_pkg::SUM_P_W'(eff_pt) + prba_pkg::SUM_P_W'(r_in.point_count);

        over_bytes  = byte_sum > prba_pkg::SUM_B_W'(r_stream_budget);
        force_ok    = (eff_pf < r_prefetch_slots) & r_keep_coarse & (r_in.level != '0);
        d_pf        = r_in.is_prefetch | over_bytes;
        skip_bytes  = over_bytes & !force_ok;
        // a prefetch page is not held to the point budget
        skip_points = !skip_bytes & !d_pf & (r_point_limit != '0)
                    & (point_sum > prba_pkg::SUM_P_W'(r_point_limit));
        admit       = !skip_bytes & !skip_points;
        // upload room left covers the page; an empty page always fits
        upload_ok   = (upload_sum <= prba_pkg::SUM_B_W'(r_upload_budget))
                    | (r_in.page_bytes == '0);

        n_plan.page = r_in;
        n_plan.pf   = admit & d_pf;
        if (skip_bytes) begin
            n_first_kind     = prba_pkg::KIND_SKIP_BYTES;
            n_plan.last_kind = prba_pkg::KIND_SKIP_BYTES;
        end else if (skip_points) begin
            n_first_kind     = prba_pkg::KIND_SKIP_POINTS;
            n_plan.last_kind = prba_pkg::KIND_SKIP_POINTS;
        end else begin
            n_first_kind = prba_pkg::KIND_REQUEST;
            if (!upload_ok)
                n_plan.last_kind = prba_pkg::KIND_READ;
            else if (d_pf)
                n_plan.last_kind = prba_pkg::KIND_BIND;
            else
                n_plan.last_kind = prba_pkg::KIND_DRAW;
        end

        // saturating accumulator updates
        n_bytes_taken    = eff_bt;
        n_bytes_uploaded = eff_bu;
        n_points_taken   = eff_pt;
        n_prefetch_taken = eff_pf;
        if (admit) begin
            n_bytes_taken = byte_sum[prba_pkg::ACC_B_W] ? '1 : byte_sum[prba_pkg::ACC_B_W-1:0];
            if (upload_ok)
                n_bytes_uploaded = upload_sum[prba_pkg::ACC_B_W] ? '1
                                 : upload_sum[prba_pkg::ACC_B_W-1:0];
            if (!d_pf)
                n_points_taken = point_sum[prba_pkg::ACC_P_W] ? '1
                               : point_sum[prba_pkg::ACC_P_W-1:0];
            else if (eff_pf != '1)
                n_prefetch_taken = eff_pf + prba_pkg::SLOT_W'(1);
        end
    end

    //--------------------------------------------------------------------------------------
    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld         <= 1'b0;
            r_plan_vld       <= 1'b0;
            r_kind           <= prba_pkg::KIND_REQUEST;
            r_bytes_taken    <= '0;
            r_bytes_uploaded <= '0;
            r_points_taken   <= '0;
            r_prefetch_taken <= '0;
        end else begin
            if (in_fire)
                r_in_vld <= 1'b1;
            else if (plan_load)
                r_in_vld <= 1'b0;

            if (plan_load) begin
                r_plan_vld       <= 1'b1;
                r_kind           <= n_first_kind;
                r_bytes_taken    <= n_bytes_taken;
                r_bytes_uploaded <= n_bytes_uploaded;
                r_points_taken   <= n_points_taken;
                r_prefetch_taken <= n_prefetch_taken;
            end else if (cmd_fire & cmd_last) begin
                r_plan_vld <= 1'b0;
            end else if (cmd_fire) begin
                r_kind <= prba_pkg::t_kind'(r_kind + prba_pkg::KIND_W'(1));
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.frame_start <= i_page.frame_start;
            r_in.page_tag    <= i_page.page_tag;
            r_in.level       <= i_page.level;
            r_in.point_count <= i_page.point_count;
            r_in.page_bytes  <= i_page.page_bytes;
            r_in.is_prefetch <= i_page.is_prefetch;
            r_in.attr_mask   <= i_page.attr_mask;
            r_in.gpu_token   <= i_page.gpu_token;
        end
        if (plan_load)
            r_plan <= n_plan;
    end

    //--------------------------------------------------------------------------------------
    // command word
    assign o_cmd.valid       = r_plan_vld;
    assign o_cmd.kind        = r_kind;
    assign o_cmd.out_tag     = r_plan.page.page_tag;
    assign o_cmd.out_level   = r_plan.page.level;
    assign o_cmd.out_bytes   = (r_kind == prba_pkg::KIND_READ || r_kind == prba_pkg::KIND_UPLOAD
                                || r_kind == prba_pkg::KIND_DRAW) ? r_plan.page.page_bytes : '0;
    assign o_cmd.out_attr    = r_plan.page.attr_mask;
    assign o_cmd.out_token   = r_plan.page.gpu_token;
    assign o_cmd.as_prefetch = r_plan.pf;
    assign o_cmd.last        = cmd_last;

endmodule

### rtl/prba_checker.sv
// Port-level checker for page admission, bound to the top level
`timescale 1ns / 1ps
`include "page_residency_budget_admission_assert.svh"

module prba_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cmd_valid,
    input logic                         i_cmd_ready,
    input logic [prba_pkg::KIND_W-1:0]  i_kind,
    input logic [prba_pkg::TAG_W-1:0]   i_tag,
    input logic                         i_as_prefetch,
    input logic                         i_last
);

    logic w_fire, w_skip;
    logic [prba_pkg::KIND_W+prba_pkg::TAG_W+1:0] w_word;

    assign w_fire = i_cmd_valid & i_cmd_ready;
    assign w_skip = (i_kind == prba_pkg::KIND_SKIP_BYTES) || (i_kind == prba_pkg::KIND_SKIP_POINTS);
    assign w_word = {i_kind, i_tag, i_as_prefetch, i_last};

    // a stalled word holds
    `PRBA_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_cmd_valid && !i_cmd_ready, i_cmd_valid && $stable(w_word))

    // within a page the kinds step up one by one with no gap, same tag
    `PRBA_ASSERT_NEXT(a_kind_step, i_clk, i_rst_n, w_fire && !i_last, i_cmd_valid && (i_kind == $past(i_kind) + 3'd1) && $stable(i_tag))

    // a skip is a lone word and never a prefetch
    `PRBA_ASSERT_NOW(a_skip_alone, i_clk, i_rst_n, i_cmd_valid && w_skip, i_last && !i_as_prefetch)

    `PRBA_ASSERT_RESET(a_reset_quiet, i_clk, !i_rst_n, !i_cmd_valid)

endmodule

bind page_residency_budget_admission prba_checker u_prba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (o_cmd.valid),
    .i_cmd_ready   (o_cmd.ready),
    .i_kind        (o_cmd.kind),
    .i_tag         (o_cmd.out_tag),
    .i_as_prefetch (o_cmd.as_prefetch),
    .i_last        (o_cmd.last)
);

### bench/tb_page_residency_budget_admission.sv
// Testbench: page admission command words checked against an in-bench budget predictor
`timescale 1ns / 1ps

module tb_page_residency_budget_admission;

    localparam logic [prba_pkg::ACC_B_W-1:0]   BYTE_ACC_MAX    = '1;
    localparam logic [prba_pkg::ACC_P_W-1:0]   POINT_ACC_MAX   = '1;
    localparam logic [prba_pkg::BYTES_W-1:0]   PAGE_BYTES_MAX  = '1;
    localparam logic [prba_pkg::PTS_W-1:0]     POINT_COUNT_MAX = '1;
    localparam logic [prba_pkg::SLOT_W-1:0]    SLOT_MAX        = '1;
    localparam logic [prba_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED  = 3'd7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 16;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_PAGES  = 8;
    localparam int SAT_PAGES    = 260;
    localparam int SAT_SMALL    = 256;

    typedef struct packed {
        logic [prba_pkg::KIND_W-1:0]  kind;
        logic [prba_pkg::TAG_W-1:0]   tag;
        logic [prba_pkg::LVL_W-1:0]   level;
        logic [prba_pkg::BYTES_W-1:0] bytes;
        logic [prba_pkg::ATTR_W-1:0]  attr;
        logic [prba_pkg::TOKEN_W-1:0] token;
        logic                         pf;
        logic                         last;
    } t_cmd_word;

    class t_admission_scoreboard;
        logic [prba_pkg::ACC_B_W-1:0] frame_budget;
        logic [prba_pkg::ACC_B_W-1:0] resident_limit;
        logic [prba_pkg::ACC_B_W-1:0] upload_budget;
        logic [prba_pkg::ACC_P_W-1:0] point_limit;
        logic [prba_pkg::SLOT_W-1:0]  page_limit;
        logic [prba_pkg::SLOT_W-1:0]  prefetch_slots;
        logic                         keep_coarse;
        logic [prba_pkg::ACC_B_W-1:0] bytes_taken;
        logic [prba_pkg::ACC_B_W-1:0] bytes_uploaded;
        logic [prba_pkg::ACC_P_W-1:0] points_taken;
        logic [prba_pkg::SLOT_W-1:0]  pages_taken;
        logic [prba_pkg::SLOT_W-1:0]  prefetch_taken;
        t_cmd_word                    pending_cmds[$];
        int                           mismatches;

        function new();
            frame_budget   = '0;
            resident_limit = '0;
            upload_budget  = '0;
            point_limit    = '0;
            page_limit     = '0;
            prefetch_slots = '0;
            keep_coarse    = 1'b0;
            clear_frame();
            mismatches     = 0;
        endfunction

        function void clear_frame();
            bytes_taken    = '0;
            bytes_uploaded = '0;
            points_taken   = '0;
            pages_taken    = '0;
            prefetch_taken = '0;
        endfunction

        function void write_reg(logic [prba_pkg::CFG_IDX_W-1:0] idx,
                                logic [prba_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                prba_pkg::CFG_FRAME_BUDGET:   frame_budget   = data;
                prba_pkg::CFG_RESIDENT_LIMIT: resident_limit = data;
                prba_pkg::CFG_UPLOAD_BUDGET:  upload_budget  = data;
                prba_pkg::CFG_POINT_LIMIT:    point_limit    = data[prba_pkg::ACC_P_W-1:0];
                prba_pkg::CFG_PAGE_LIMIT:     page_limit     = data[prba_pkg::SLOT_W-1:0];
                prba_pkg::CFG_PREFETCH_SLOTS: prefetch_slots = data[prba_pkg::SLOT_W-1:0];
                prba_pkg::CFG_KEEP_COARSE:    keep_coarse    = data[0];
                default: ;
            endcase
        endfunction

        function logic [prba_pkg::ACC_B_W-1:0] sat_bytes(logic [prba_pkg::ACC_B_W-1:0] a,
                                                         logic [prba_pkg::BYTES_W-1:0] b);
            logic [prba_pkg::ACC_B_W:0] s;
            s = {1'b0, a} + b;
            return s[prba_pkg::ACC_B_W] ? BYTE_ACC_MAX : s[prba_pkg::ACC_B_W-1:0];
        endfunction

        function logic [prba_pkg::ACC_P_W-1:0] sat_points(logic [prba_pkg::ACC_P_W-1:0] a,
                                                          logic [prba_pkg::PTS_W-1:0] b);
            logic [prba_pkg::ACC_P_W:0] s;
            s = {1'b0, a} + b;
            return s[prba_pkg::ACC_P_W] ? POINT_ACC_MAX : s[prba_pkg::ACC_P_W-1:0];
        endfunction

        function t_cmd_word word_of(prba_pkg::t_page p, logic [prba_pkg::KIND_W-1:0] kind,
                                    logic [prba_pkg::BYTES_W-1:0] bytes, logic pf);
            t_cmd_word w;
            w.kind  = kind;
            w.tag   = p.page_tag;
            w.level = p.level;
            w.bytes = bytes;
            w.attr  = p.attr_mask;
            w.token = p.gpu_token;
            w.pf    = pf;
            w.last  = 1'b0;
            return w;
        endfunction

        function void predict_commands(prba_pkg::t_page p);
            t_cmd_word                    words[$];
            t_cmd_word                    w;
            logic [prba_pkg::ACC_B_W:0]   byte_sum;
            logic [prba_pkg::ACC_P_W:0]   point_sum;
            logic [prba_pkg::ACC_B_W-1:0] stream_budget;
            logic [prba_pkg::ACC_B_W-1:0] upload_left;
            logic                         pf;

            if (p.frame_start)
                clear_frame();
            pf            = p.is_prefetch;
            stream_budget = (frame_budget < resident_limit) ? frame_budget : resident_limit;
            // sums kept one bit wider so the comparison sees the true total
            byte_sum      = {1'b0, bytes_taken} + p.page_bytes;
            point_sum     = {1'b0, points_taken} + p.point_count;

            if (byte_sum > {1'b0, stream_budget}) begin
                if (prefetch_taken < prefetch_slots && keep_coarse && p.level != '0) begin
                    pf = 1'b1;
                end else begin
                    w = word_of(p, prba_pkg::KIND_SKIP_BYTES, '0, 1'b0);
                    w.last = 1'b1;
                    pending_cmds.insert(pending_cmds.size(), w);
                    return;
                end
            end
            if (!pf && point_limit != '0 && point_sum > {1'b0, point_limit}) begin
                w = word_of(p, prba_pkg::KIND_SKIP_POINTS, '0, 1'b0);
                w.last = 1'b1;
                pending_cmds.insert(pending_cmds.size(), w);
                return;
            end

            words.insert(words.size(), word_of(p, prba_pkg::KIND_REQUEST, '0, pf));
            words.insert(words.size(), word_of(p, prba_pkg::KIND_READ, p.page_bytes, pf));
            upload_left = (upload_budget > bytes_uploaded) ? upload_budget - bytes_uploaded : '0;
            if (upload_left >= p.page_bytes) begin
                words.insert(words.size(), word_of(p, prba_pkg::KIND_UPLOAD, p.page_bytes, pf));
                words.insert(words.size(), word_of(p, prba_pkg::KIND_BIND, '0, pf));
                bytes_uploaded = sat_bytes(bytes_uploaded, p.page_bytes);
                if (!pf)
                    words.insert(words.size(),
                                 word_of(p, prba_pkg::KIND_DRAW, p.page_bytes, pf));
            end
            w = words[words.size() - 1];
            w.last = 1'b1;
            words[words.size() - 1] = w;

            bytes_taken = sat_bytes(bytes_taken, p.page_bytes);
            if (!pf)
                points_taken = sat_points(points_taken, p.point_count);
            if (pages_taken != SLOT_MAX)
                pages_taken = pages_taken + 1'b1;
            if (pf && prefetch_taken != SLOT_MAX)
                prefetch_taken = prefetch_taken + 1'b1;
            foreach (words[i])
                pending_cmds.insert(pending_cmds.size(), words[i]);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, actual %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_command(t_cmd_word got);
            t_cmd_word want;
            if (pending_cmds.size() == 0) begin
                $error("unexpected command word: kind %0d tag %0h", got.kind, got.tag);
                mismatches++;
                return;
            end
            want = pending_cmds.pop_front();
            compare_field("kind", 64'(want.kind), 64'(got.kind));
            compare_field("out_tag", 64'(want.tag), 64'(got.tag));
            compare_field("out_level", 64'(want.level), 64'(got.level));
            compare_field("out_bytes", 64'(want.bytes), 64'(got.bytes));
            compare_field("out_attr", 64'(want.attr), 64'(got.attr));
            compare_field("out_token", want.token, got.token);
            compare_field("as_prefetch", 64'(want.pf), 64'(got.pf));
            compare_field("last", 64'(want.last), 64'(got.last));
        endfunction

        function int outstanding();
            return pending_cmds.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    prba_cfg_if  cfg_bus();
    prba_page_if page_bus();
    prba_cmd_if  cmd_bus();

    page_residency_budget_admission uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_page  (page_bus),
        .o_cmd   (cmd_bus)
    );

    t_admission_scoreboard               sb;
    bit                                  calm;
    int                                  cycle_count;
    logic [prba_pkg::CFG_IDX_W-1:0]      reg_idx_q[$];
    logic [prba_pkg::CFG_DATA_W-1:0]     reg_val_q[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_page_residency_budget_admission NOT OK");
        $finish;
    end

    // command sink: random stall before each word, check on every accepted word
    initial begin
        int        stall;
        t_cmd_word got;
        cmd_bus.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                cmd_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            cmd_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(cmd_bus.valid && cmd_bus.ready));
            got.kind  = cmd_bus.kind;
            got.tag   = cmd_bus.out_tag;
            got.level = cmd_bus.out_level;
            got.bytes = cmd_bus.out_bytes;
            got.attr  = cmd_bus.out_attr;
            got.token = cmd_bus.out_token;
            got.pf    = cmd_bus.as_prefetch;
            got.last  = cmd_bus.last;
            sb.check_command(got);
        end
    end

    function automatic logic [63:0] rand_bits(int n);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (n < 64)
            v = v & ((64'd1 << n) - 64'd1);
        return v;
    endfunction

    function automatic prba_pkg::t_page make_page(logic fs, logic [prba_pkg::LVL_W-1:0] level,
                                                  logic [prba_pkg::PTS_W-1:0] points,
                                                  logic [prba_pkg::BYTES_W-1:0] bytes,
                                                  logic pf);
        prba_pkg::t_page p;
        p.frame_start = fs;
        p.page_tag    = $urandom;
        p.level       = level;
        p.point_count = points;
        p.page_bytes  = bytes;
        p.is_prefetch = pf;
        p.attr_mask   = prba_pkg::ATTR_W'($urandom);
        p.gpu_token   = {$urandom, $urandom};
        return p;
    endfunction

    // byte and point sizes spread around the scale chosen for the phase
    function automatic prba_pkg::t_page random_page(int byte_bits, int point_bits);
        prba_pkg::t_page p;
        p = make_page($urandom_range(0, 9) == 0,
                      ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(1, 15)),
                      '0, '0, $urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
            0:       p.point_count = '0;
            1:       p.point_count = POINT_COUNT_MAX;
            2, 3:    p.point_count = $urandom;
            default: p.point_count = prba_pkg::PTS_W'(rand_bits(point_bits));
        endcase
        case ($urandom_range(0, 9))
            0:       p.page_bytes = '0;
            1:       p.page_bytes = PAGE_BYTES_MAX;
            2:       p.page_bytes = prba_pkg::BYTES_W'(rand_bits(prba_pkg::BYTES_W));
            3:       p.page_bytes = prba_pkg::BYTES_W'(rand_bits(2));
            default: p.page_bytes = prba_pkg::BYTES_W'(rand_bits(byte_bits));
        endcase
        return p;
    endfunction

    task automatic stage_reg(input logic [prba_pkg::CFG_IDX_W-1:0] idx,
                             input logic [prba_pkg::CFG_DATA_W-1:0] val);
        reg_idx_q.insert(reg_idx_q.size(), idx);
        reg_val_q.insert(reg_val_q.size(), val);
    endtask

    task automatic stage_all(input logic [prba_pkg::ACC_B_W-1:0] frame,
                             input logic [prba_pkg::ACC_B_W-1:0] resident,
                             input logic [prba_pkg::ACC_B_W-1:0] upload,
                             input logic [prba_pkg::ACC_P_W-1:0] points,
                             input logic [prba_pkg::SLOT_W-1:0] pages,
                             input logic [prba_pkg::SLOT_W-1:0] slots,
                             input logic keep);
        stage_reg(prba_pkg::CFG_FRAME_BUDGET, frame);
        stage_reg(prba_pkg::CFG_RESIDENT_LIMIT, resident);
        stage_reg(prba_pkg::CFG_UPLOAD_BUDGET, upload);
        stage_reg(prba_pkg::CFG_POINT_LIMIT, prba_pkg::CFG_DATA_W'(points));
        stage_reg(prba_pkg::CFG_PAGE_LIMIT, prba_pkg::CFG_DATA_W'(pages));
        stage_reg(prba_pkg::CFG_PREFETCH_SLOTS, prba_pkg::CFG_DATA_W'(slots));
        stage_reg(prba_pkg::CFG_KEEP_COARSE, prba_pkg::CFG_DATA_W'(keep));
    endtask

    // valid held high across back-to-back writes
    task automatic apply_regs();
        while (reg_idx_q.size() != 0) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= reg_idx_q[0];
            cfg_bus.data  <= reg_val_q[0];
            do @(posedge i_clk); while (!cfg_bus.ready);
            sb.write_reg(reg_idx_q.pop_front(), reg_val_q.pop_front());
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic drain_all();
        page_bus.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_page(input prba_pkg::t_page p);
        int gap;
        if ($urandom_range(0, 24) == 0)
            calm = ~calm;
        gap = calm ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 39) == 0 && sb.outstanding() != 0) begin
            page_bus.valid <= 1'b0;
            while (sb.outstanding() != 0)
                @(posedge i_clk);
        end else if (gap > 0) begin
            page_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        page_bus.valid       <= 1'b1;
        page_bus.frame_start <= p.frame_start;
        page_bus.page_tag    <= p.page_tag;
        page_bus.level       <= p.level;
        page_bus.point_count <= p.point_count;
        page_bus.page_bytes  <= p.page_bytes;
        page_bus.is_prefetch <= p.is_prefetch;
        page_bus.attr_mask   <= p.attr_mask;
        page_bus.gpu_token   <= p.gpu_token;
        do @(posedge i_clk); while (!page_bus.ready);
        sb.predict_commands(p);
    endtask

    initial begin
        prba_pkg::t_page p;
        int              byte_bits;
        int              point_bits;

        sb   = new();
        calm = 1'b0;
        i_rst_n              = 1'b0;
        page_bus.valid       = 1'b0;
        page_bus.frame_start = 1'b0;
        page_bus.page_tag    = '0;
        page_bus.level       = '0;
        page_bus.point_count = '0;
        page_bus.page_bytes  = '0;
        page_bus.is_prefetch = 1'b0;
        page_bus.attr_mask   = '0;
        page_bus.gpu_token   = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = '0;
        cfg_bus.data         = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // tight budgets: boundary equality, forced prefetch, slot exhaustion, upload shortfall
        stage_all(BYTE_ACC_MAX, 48'd1000, 48'd700, 40'd1000, SLOT_MAX, 16'd2, 1'b1);
        apply_regs();
        send_page(make_page(1'b1, 4'd0, 32'd300, 40'd400, 1'b0));
        send_page(make_page(1'b0, 4'd0, 32'd700, 40'd600, 1'b0));
        send_page(make_page(1'b0, 4'd0, 32'd0, 40'd1, 1'b0));
        send_page(make_page(1'b0, 4'd3, 32'd5, 40'd1, 1'b0));
        send_page(make_page(1'b0, 4'd0, 32'd1, 40'd0, 1'b0));
        send_page(make_page(1'b0, 4'd15, 32'd1, 40'd0, 1'b0));
        send_page(make_page(1'b0, 4'd5, 32'd1, 40'd0, 1'b0));
        send_page(make_page(1'b1, 4'd0, POINT_COUNT_MAX, 40'd300, 1'b1));
        send_page(make_page(1'b0, 4'd2, 32'd1001, 40'd100, 1'b0));
        send_page(make_page(1'b0, 4'd2, 32'd1000, 40'd100, 1'b0));
        send_page(make_page(1'b0, 4'd1, 32'd0, 40'd600, 1'b0));
        send_page(make_page(1'b1, 4'd1, 32'd0, 40'd1000, 1'b0));
        send_page(make_page(1'b0, 4'd0, 32'd0, 40'd0, 1'b0));
        drain_all();

        // wide open budgets, field extremes, write to the unused index
        stage_all(BYTE_ACC_MAX, BYTE_ACC_MAX, BYTE_ACC_MAX, POINT_ACC_MAX, SLOT_MAX, SLOT_MAX,
                  1'b1);
        stage_reg(CFG_IDX_UNUSED, '0);
        apply_regs();
        p = '1;
        p.is_prefetch = 1'b0;
        send_page(p);
        p = '0;
        p.frame_start = 1'b1;
        send_page(p);
        drain_all();

        // zero budgets, unlimited points, no forced prefetch
        stage_all('0, BYTE_ACC_MAX, '0, '0, '0, '0, 1'b0);
        apply_regs();
        send_page(make_page(1'b1, 4'd0, POINT_COUNT_MAX, 40'd0, 1'b0));
        send_page(make_page(1'b0, 4'd0, 32'd3, 40'd1, 1'b0));
        send_page(make_page(1'b0, 4'd4, 32'd3, 40'd1, 1'b0));
        send_page(make_page(1'b1, 4'd7, 32'd3, 40'd0, 1'b1));
        drain_all();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            byte_bits  = $urandom_range(6, 38);
            point_bits = $urandom_range(4, 34);
            if (ph == 0) begin
                stage_all(BYTE_ACC_MAX, BYTE_ACC_MAX, BYTE_ACC_MAX, '0, SLOT_MAX, SLOT_MAX, 1'b1);
            end else if (ph == 1) begin
                stage_all('0, '0, '0, '0, '0, '0, 1'b0);
            end else begin
                stage_all(prba_pkg::ACC_B_W'(($urandom_range(0, 3) == 0) ? BYTE_ACC_MAX
                                             : rand_bits(byte_bits + 3)),
                          prba_pkg::ACC_B_W'(($urandom_range(0, 3) == 0) ? BYTE_ACC_MAX
                                             : rand_bits(byte_bits + 3)),
                          prba_pkg::ACC_B_W'(($urandom_range(0, 5) == 0) ? '0
                                             : rand_bits(byte_bits + 2)),
                          prba_pkg::ACC_P_W'(($urandom_range(0, 2) == 0) ? '0
                                             : rand_bits(point_bits + 3)),
                          prba_pkg::SLOT_W'($urandom),
                          ($urandom_range(0, 3) == 0) ? SLOT_MAX : 16'($urandom_range(0, 6)),
                          1'($urandom_range(0, 1)));
            end
            apply_regs();
            for (int i = 0; i < PHASE_PAGES; i++) begin
                p = random_page(byte_bits, point_bits);
                if (i == 0)
                    p.frame_start = 1'b1;
                send_page(p);
            end
            drain_all();
        end

        // full pages fill the byte budget to just short of its ceiling, one small page then
        // tips the point total into saturation, and forced prefetches saturate the bytes
        calm = 1'b1;
        stage_all(BYTE_ACC_MAX, BYTE_ACC_MAX, BYTE_ACC_MAX, '0, SLOT_MAX, SLOT_MAX, 1'b1);
        apply_regs();
        for (int i = 0; i < SAT_PAGES; i++)
            send_page(make_page(i == 0, prba_pkg::LVL_W'($urandom_range(1, 15)),
                                POINT_COUNT_MAX,
                                (i == SAT_SMALL) ? prba_pkg::BYTES_W'(rand_bits(8))
                                                 : PAGE_BYTES_MAX,
                                1'b0));
        drain_all();

        // probe both saturated totals against full limits
        stage_reg(prba_pkg::CFG_POINT_LIMIT, prba_pkg::CFG_DATA_W'(POINT_ACC_MAX));
        apply_regs();
        send_page(make_page(1'b0, 4'd0, 32'd1, 40'd0, 1'b0));
        send_page(make_page(1'b0, 4'd0, 32'd0, 40'd0, 1'b0));
        send_page(make_page(1'b0, 4'd0, 32'd5, 40'd1, 1'b1));
        send_page(make_page(1'b0, 4'd2, 32'd5, 40'd1, 1'b0));
        calm = 1'b0;

        drain_all();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb_page_residency_budget_admission OK");
        else
            $display("tb_page_residency_budget_admission NOT OK");
        $finish;
    end

endmodule
